### design/ece_pkg.sv
package ece_pkg;

	localparam int FRAC_BITS        = 16;
	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int MODE_W  = 4;
	localparam int PROG_W  = FRAC_BITS + 2;
	localparam int EASED_W = FRAC_BITS + 1;
	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_STEP         = 4'd0,
		MODE_LINEAR       = 4'd1,
		MODE_IN_QUAD      = 4'd2,
		MODE_OUT_QUAD     = 4'd3,
		MODE_INOUT_QUAD   = 4'd4,
		MODE_IN_CUBIC     = 4'd5,
		MODE_OUT_CUBIC    = 4'd6,
		MODE_INOUT_CUBIC  = 4'd7,
		MODE_IN_SINE      = 4'd8,
		MODE_OUT_SINE     = 4'd9
	} mode_t;

	typedef logic [FRAC_BITS:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int          TAYLOR_TERMS = 10;
	// Divisor of term n in the series is (2n)(2n+1).
	localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	// Quarter-wave sine table, evaluated once at elaboration from a Q30 Taylor series.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		logic [63:0] one64;
		int          shift;
		shift = 30 - FRAC_BITS;
		one64 = 64'd1 << FRAC_BITS;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if ((n & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			r = (sum + (64'd1 << (shift - 1))) >> shift;
			if (r > one64) begin
				r = one64;
			end
			rom[k] = r[FRAC_BITS:0];
		end
		return rom;
	endfunction

endpackage

### design/easing_curve_evaluator_core.sv
// Easing curve evaluator: four register stages, one request accepted in every cycle.
// The result passes the s1, s2 and s3 registers and is driven on eased, with done, from s4;
// the two multipliers in series set the pipeline depth.
// Throughput is one result per cycle; busy is always low, as the result side never stalls.
// Reset clears the stage valid bits only; the sine table is a constant ROM and needs
// no clearing pass.
module easing_curve_evaluator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ece_pkg::MODE_W-1:0]     mode,
	input  logic signed [ece_pkg::PROG_W-1:0] progress,
	output logic                           done,
	output logic [ece_pkg::EASED_W-1:0]    eased
);
	import ece_pkg::*;

	localparam int TW  = FRAC_BITS + 1;
	localparam int OPW = FRAC_BITS + 2;
	localparam int P1W = 2 * OPW - FRAC_BITS;
	localparam int P2W = FRAC_BITS + 2;
	localparam int PW  = FRAC_BITS + IDX_W;
	localparam int DW  = 2 * FRAC_BITS + 2;

	localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SINE_TABLE_DEPTH);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Stage 1: clamp and operand selection for the first multiplier.
	logic [PROG_W-1:0] raw;
	logic [TW-1:0]     t;
	logic [TW-1:0]     u;
	logic              half;
	logic [OPW-1:0]    t_ext;
	logic [OPW-1:0]    u_ext;
	logic [OPW-1:0]    opa;
	logic [OPW-1:0]    opb;
	logic [TW-1:0]     sarg;

	assign raw = progress;

	always_comb begin
		if (raw[PROG_W-1]) begin
			t = '0;
		end else if (raw[PROG_W-2:0] > (PROG_W-1)'(ONE)) begin
			t = ONE;
		end else begin
			t = raw[TW-1:0];
		end
		u     = ONE - t;
		half  = (t < HALF);
		t_ext = OPW'(t);
		u_ext = OPW'(u);
		sarg  = (mode == MODE_IN_SINE) ? u : t;
	end

	always_comb begin
		opa = t_ext;
		opb = t_ext;
		case (mode)
			MODE_OUT_QUAD: begin
				opb = (OPW'(ONE) << 1) - t_ext;
			end
			MODE_INOUT_QUAD: begin
				// Four times one is zero at this width, so the upper half is 0 - 2t.
				opa = half ? (t_ext << 1) : (OPW'(0) - (t_ext << 1));
			end
			MODE_OUT_CUBIC: begin
				opa = u_ext;
				opb = u_ext;
			end
			MODE_INOUT_CUBIC: begin
				opa = half ? (t_ext << 2) : u_ext;
				opb = half ? t_ext : (u_ext << 1);
			end
			default: ;
		endcase
	end

	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [TW-1:0]     t_s1;
	logic [TW-1:0]     u_s1;
	logic              half_s1;
	logic [OPW-1:0]    opa_s1;
	logic [OPW-1:0]    opb_s1;
	logic [TW-1:0]     sarg_s1;

	// Stage 2: first product and the two table reads.
	logic [2*OPW-1:0]  prod1;
	logic [PW-1:0]     spos;
	logic [IDX_W-1:0]  k0;
	logic [IDX_W-1:0]  k1;

	assign prod1 = opa_s1 * opb_s1;
	assign spos  = PW'(sarg_s1) * PW'(SINE_TABLE_DEPTH);
	assign k0    = spos[PW-1:FRAC_BITS];
	// At the top of the table the next entry is the same one.
	assign k1    = (k0 < LAST_IDX) ? (k0 + IDX_W'(1)) : k0;

	logic              valid_s2;
	logic [MODE_W-1:0] mode_s2;
	logic [TW-1:0]     t_s2;
	logic [TW-1:0]     u_s2;
	logic              half_s2;
	logic [P1W-1:0]    p1_s2;
	logic [TW-1:0]     e0_s2;
	logic [TW-1:0]     e1_s2;
	logic [FRAC_BITS-1:0] f_s2;

	// Stage 3: second product for the cubics and the interpolation product.
	logic [TW-1:0]     opc;
	logic [2*TW-1:0]   prod2;
	logic [TW-1:0]     sdiff;

	always_comb begin
		case (mode_s2)
			MODE_OUT_CUBIC:   opc = u_s2;
			MODE_INOUT_CUBIC: opc = half_s2 ? t_s2 : (u_s2 << 1);
			default:          opc = t_s2;
		endcase
	end

	assign prod2 = p1_s2[TW-1:0] * opc;
	assign sdiff = (e1_s2 > e0_s2) ? (e1_s2 - e0_s2) : '0;

	logic              valid_s3;
	logic [MODE_W-1:0] mode_s3;
	logic [TW-1:0]     t_s3;
	logic              half_s3;
	logic [P1W-1:0]    p1_s3;
	logic [P2W-1:0]    p2_s3;
	logic [TW-1:0]     e0_s3;
	logic [DW-1:0]     dprod_s3;

	// Stage 4: rounding of the interpolation, curve select and final clamp.
	logic [DW-1:0]     dsum;
	logic [P1W-1:0]    sine_val;
	logic [P1W-1:0]    p2_ext;
	logic [P1W-1:0]    one_ext;
	logic [P1W-1:0]    res;
	logic [TW-1:0]     res_clamped;

	always_comb begin
		dsum     = dprod_s3 + DW'(HALF);
		sine_val = P1W'(e0_s3) + P1W'(dsum >> FRAC_BITS);
		p2_ext   = P1W'(p2_s3);
		one_ext  = P1W'(ONE);
		case (mode_s3)
			MODE_STEP:        res = (t_s3 == ONE) ? one_ext : '0;
			MODE_IN_QUAD:     res = p1_s3;
			MODE_OUT_QUAD:    res = p1_s3;
			MODE_INOUT_QUAD:  res = half_s3 ? p1_s3 : (p1_s3 - one_ext);
			MODE_IN_CUBIC:    res = p2_ext;
			MODE_OUT_CUBIC:   res = one_ext - p2_ext;
			MODE_INOUT_CUBIC: res = half_s3 ? p2_ext : (one_ext - p2_ext);
			MODE_IN_SINE:     res = one_ext - sine_val;
			MODE_OUT_SINE:    res = sine_val;
			default:          res = P1W'(t_s3);
		endcase
		res_clamped = (res > one_ext) ? ONE : res[TW-1:0];
	end

	logic              done_s4;
	logic [TW-1:0]     eased_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_s4  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_s4  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		t_s1     <= t;
		u_s1     <= u;
		half_s1  <= half;
		opa_s1   <= opa;
		opb_s1   <= opb;
		sarg_s1  <= sarg;

		mode_s2  <= mode_s1;
		t_s2     <= t_s1;
		u_s2     <= u_s1;
		half_s2  <= half_s1;
		p1_s2    <= prod1[2*OPW-1:FRAC_BITS];
		e0_s2    <= SINE_ROM[k0];
		e1_s2    <= SINE_ROM[k1];
		f_s2     <= spos[FRAC_BITS-1:0];

		mode_s3  <= mode_s2;
		t_s3     <= t_s2;
		half_s3  <= half_s2;
		p1_s3    <= p1_s2;
		p2_s3    <= prod2[2*TW-1:FRAC_BITS];
		e0_s3    <= e0_s2;
		dprod_s3 <= DW'(sdiff) * DW'(f_s2);

		eased_s4 <= res_clamped;
	end

	assign busy  = 1'b0;
	assign done  = done_s4;
	assign eased = eased_s4;

endmodule
